[rtl/core/tts_pkg.sv]
package tts_pkg;

	localparam int TARGET_COUNT = 3;
	localparam int CLOCK_WIDTH = 24;
	localparam int MS_WIDTH = 16;

	localparam int APB_DATA_WIDTH = 32;
	localparam int CFG_REG_COUNT = 2 * TARGET_COUNT;
	localparam int CFG_ADDR_WIDTH = $clog2(4 * CFG_REG_COUNT);
	localparam int CFG_INDEX_WIDTH = CFG_ADDR_WIDTH - 2;

	typedef logic [MS_WIDTH-1:0] ms_t;
	typedef logic [CLOCK_WIDTH-1:0] clk_t;

	localparam ms_t MAX_MS = ms_t'(60000);
	localparam ms_t MIN_DURATION = ms_t'(100);
	localparam ms_t DEFAULT_DURATION = ms_t'(2000);
	localparam int DELAY_STEP = 1000;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_SHOT  = 3'd1,
		OP_STOP  = 3'd2,
		OP_ARM   = 3'd3,
		OP_RESET = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_HIDDEN = 2'd0,
		ST_SHOWN  = 2'd1,
		ST_ERROR  = 2'd2,
		ST_MOVING = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_SHOW  = 3'd1,
		CMD_HIDE  = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_RESET = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_RUN  = 2'd2,
		MODE_DONE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0]                   operation;
		status_t [TARGET_COUNT-1:0]   status;
	} step_in_t;

	typedef struct packed {
		cmd_t [TARGET_COUNT-1:0]      command;
		mode_t                        run_mode;
		logic                         aborted;
	} step_out_t;

	typedef struct packed {
		ms_t [TARGET_COUNT-1:0]       delay;
		ms_t [TARGET_COUNT-1:0]       duration;
	} timing_t;

endpackage

[rtl/core/tts_in_if.sv]
interface tts_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [1:0] first_status;
	logic [1:0] second_status;
	logic [1:0] third_status;

	modport source (
		output valid, operation, first_status, second_status, third_status,
		input  ready
	);
	modport sink (
		input  valid, operation, first_status, second_status, third_status,
		output ready
	);
endinterface

[rtl/core/tts_out_if.sv]
interface tts_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] first_command;
	logic [2:0] second_command;
	logic [2:0] third_command;
	logic [1:0] run_mode;
	logic       aborted;

	modport source (
		output valid, first_command, second_command, third_command, run_mode, aborted,
		input  ready
	);
	modport sink (
		input  valid, first_command, second_command, third_command, run_mode, aborted,
		output ready
	);
endinterface

[rtl/core/tts_cfg.sv]
module tts_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [tts_pkg::CFG_ADDR_WIDTH-1:0]    paddr,
	input  logic [tts_pkg::APB_DATA_WIDTH-1:0]    pwdata,
	output logic [tts_pkg::APB_DATA_WIDTH-1:0]    prdata,
	output logic                                  pready,
	output tts_pkg::timing_t                      timing
);
	import tts_pkg::*;

	ms_t [TARGET_COUNT-1:0] delay_q;
	ms_t [TARGET_COUNT-1:0] duration_q;
	logic                   wr;
	logic [CFG_INDEX_WIDTH-1:0] idx;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign idx = paddr[CFG_ADDR_WIDTH-1:2];

	for (genvar t = 0; t < TARGET_COUNT; t++) begin : g_reg
		localparam ms_t DELAY_RESET = ms_t'(DELAY_STEP * t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				delay_q[t]    <= DELAY_RESET;
				duration_q[t] <= DEFAULT_DURATION;
			end else if (wr) begin
				if (idx == CFG_INDEX_WIDTH'(2 * t))
					delay_q[t] <= pwdata[MS_WIDTH-1:0];
				if (idx == CFG_INDEX_WIDTH'(2 * t + 1))
					duration_q[t] <= pwdata[MS_WIDTH-1:0];
			end
		end

		// clamp on use
		assign timing.delay[t] = (delay_q[t] > MAX_MS) ? MAX_MS : delay_q[t];
		assign timing.duration[t] = (duration_q[t] < MIN_DURATION) ? MIN_DURATION :
			(duration_q[t] > MAX_MS) ? MAX_MS : duration_q[t];
	end

	always_comb begin
		prdata = '0;
		for (int t = 0; t < TARGET_COUNT; t++) begin
			if (idx == CFG_INDEX_WIDTH'(2 * t))
				prdata = APB_DATA_WIDTH'(delay_q[t]);
			if (idx == CFG_INDEX_WIDTH'(2 * t + 1))
				prdata = APB_DATA_WIDTH'(duration_q[t]);
		end
	end

endmodule

[rtl/core/tts_core.sv]
module tts_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tts_pkg::step_in_t   step_in,
	input  tts_pkg::timing_t    timing,
	output tts_pkg::step_out_t  step_out
);
	import tts_pkg::*;

	mode_t                     mode_q, mode_d;
	logic                      shot_pending_q, shot_pending_d;
	clk_t                      run_clock_q, run_clock_d;
	logic [TARGET_COUNT-1:0]   show_issued_q, show_issued_d;
	logic [TARGET_COUNT-1:0]   shown_seen_q, shown_seen_d;
	clk_t [TARGET_COUNT-1:0]   shown_time_q, shown_time_d;
	logic [TARGET_COUNT-1:0]   hide_issued_q, hide_issued_d;
	logic [TARGET_COUNT-1:0]   hidden_done_q, hidden_done_d;

	logic                      started;
	logic                      running;
	logic                      err;
	clk_t                      rc;
	logic [TARGET_COUNT-1:0]   b_show, b_seen, b_hide, b_done;
	clk_t [TARGET_COUNT-1:0]   b_time;
	logic [TARGET_COUNT-1:0]   n_show, n_seen, n_hide, n_done;
	clk_t [TARGET_COUNT-1:0]   n_time;
	cmd_t [TARGET_COUNT-1:0]   lane_cmd;

	assign started = (step_in.operation == OP_TICK) && shot_pending_q && (mode_q == MODE_WAIT);
	assign running = (step_in.operation == OP_TICK) && (started || mode_q == MODE_RUN);

	always_comb begin
		err = 1'b0;
		for (int i = 0; i < TARGET_COUNT; i++)
			if (step_in.status[i] == ST_ERROR)
				err = 1'b1;
	end

	// run starts with cleared flags and the clock at zero
	assign b_show = started ? '0 : show_issued_q;
	assign b_seen = started ? '0 : shown_seen_q;
	assign b_hide = started ? '0 : hide_issued_q;
	assign b_done = started ? '0 : hidden_done_q;
	assign b_time = started ? '0 : shown_time_q;
	assign rc = started ? '0 : ((run_clock_q == '1) ? run_clock_q : run_clock_q + 1'b1);

	for (genvar i = 0; i < TARGET_COUNT; i++) begin : g_lane
		logic show_go, seen_go, hide_go;

		assign show_go = (rc > clk_t'(timing.delay[i])) && !b_show[i];
		assign n_show[i] = b_show[i] | show_go;
		assign seen_go = n_show[i] && !b_seen[i] && (step_in.status[i] == ST_SHOWN);
		assign n_seen[i] = b_seen[i] | seen_go;
		assign n_time[i] = seen_go ? rc : b_time[i];
		assign hide_go = n_seen[i] && !b_hide[i] &&
			((rc - n_time[i]) >= clk_t'(timing.duration[i]));
		assign n_hide[i] = b_hide[i] | hide_go;
		assign n_done[i] = b_done[i] | (n_hide[i] && (step_in.status[i] == ST_HIDDEN));
		assign lane_cmd[i] = hide_go ? CMD_HIDE : (show_go ? CMD_SHOW : CMD_NONE);
	end

	always_comb begin
		mode_d         = mode_q;
		shot_pending_d = shot_pending_q;
		run_clock_d    = run_clock_q;
		show_issued_d  = show_issued_q;
		shown_seen_d   = shown_seen_q;
		shown_time_d   = shown_time_q;
		hide_issued_d  = hide_issued_q;
		hidden_done_d  = hidden_done_q;
		step_out.aborted = 1'b0;
		for (int i = 0; i < TARGET_COUNT; i++)
			step_out.command[i] = CMD_NONE;

		unique case (step_in.operation)
			OP_TICK: begin
				shot_pending_d = 1'b0;
				if (running) begin
					show_issued_d = b_show;
					shown_seen_d  = b_seen;
					shown_time_d  = b_time;
					hide_issued_d = b_hide;
					hidden_done_d = b_done;
					run_clock_d   = started ? '0 : run_clock_q;
					if (err) begin
						for (int i = 0; i < TARGET_COUNT; i++)
							step_out.command[i] = CMD_STOP;
						mode_d = MODE_IDLE;
						step_out.aborted = 1'b1;
					end else begin
						run_clock_d   = rc;
						show_issued_d = n_show;
						shown_seen_d  = n_seen;
						shown_time_d  = n_time;
						hide_issued_d = n_hide;
						hidden_done_d = n_done;
						step_out.command = lane_cmd;
						mode_d = (&n_done) ? MODE_DONE : MODE_RUN;
					end
				end
			end
			OP_SHOT: begin
				shot_pending_d = 1'b1;
			end
			OP_STOP: begin
				for (int i = 0; i < TARGET_COUNT; i++)
					step_out.command[i] = CMD_STOP;
				mode_d = MODE_IDLE;
			end
			OP_ARM: begin
				for (int i = 0; i < TARGET_COUNT; i++)
					step_out.command[i] = CMD_HIDE;
				shot_pending_d = 1'b0;
				show_issued_d  = '0;
				shown_seen_d   = '0;
				shown_time_d   = '0;
				hide_issued_d  = '0;
				hidden_done_d  = '0;
				mode_d = MODE_WAIT;
			end
			OP_RESET: begin
				for (int i = 0; i < TARGET_COUNT; i++)
					step_out.command[i] = CMD_RESET;
				mode_d = MODE_IDLE;
			end
			default: begin
			end
		endcase
		step_out.run_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			shot_pending_q <= 1'b0;
			run_clock_q    <= '0;
			show_issued_q  <= '0;
			shown_seen_q   <= '0;
			shown_time_q   <= '0;
			hide_issued_q  <= '0;
			hidden_done_q  <= '0;
		end else if (step) begin
			mode_q         <= mode_d;
			shot_pending_q <= shot_pending_d;
			run_clock_q    <= run_clock_d;
			show_issued_q  <= show_issued_d;
			shown_seen_q   <= shown_seen_d;
			shown_time_q   <= shown_time_d;
			hide_issued_q  <= hide_issued_d;
			hidden_done_q  <= hidden_done_d;
		end
	end

	a_arm_waits: assert property (@(posedge clk) disable iff (!arst_n)
		step && step_in.operation == OP_ARM |=> mode_q == MODE_WAIT && !shot_pending_q)
		else $error("arm did not enter waiting");

	a_abort_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && step_out.aborted |=> mode_q == MODE_IDLE)
		else $error("abort did not return to idle");

	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		((hide_issued_q & ~shown_seen_q) == '0) && ((shown_seen_q & ~show_issued_q) == '0))
		else $error("target flags out of order");

	a_clock_adv: assert property (@(posedge clk) disable iff (!arst_n)
		step && step_in.operation == OP_TICK && mode_q == MODE_RUN && !err &&
		run_clock_q != '1 |=> run_clock_q == $past(run_clock_q) + 1'b1)
		else $error("run clock did not advance");

endmodule

[rtl/core/three_target_timed_sequencer.sv]
// Channel  Dir  Transfer fields
// item     in   operation, first_status, second_status, third_status
// result   out  first_command, second_command, third_command, run_mode, aborted
// apb      in   psel/penable/pwrite/paddr/pwdata -> prdata, pready (always 1)
//
// One item per cycle sustained while the result moves: input register, one
// step of compare and flag logic against the run state, result register.
// An item goes through the input register, then the result register.
// Result stalls hold the result register; the input register keeps taking
// items as long as the result moves. arst_n clears the valid flags and run
// state and loads register defaults, data registers aside; no clearing pass.
module three_target_timed_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tts_in_if.sink                               item,
	tts_out_if.source                            result,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tts_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
	input  logic [tts_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	output logic [tts_pkg::APB_DATA_WIDTH-1:0]   prdata,
	output logic                                 pready
);
	import tts_pkg::*;

	timing_t    timing;
	logic       item_valid_s1;
	step_in_t   item_s1;
	logic       res_valid_q;
	step_out_t  res_q;
	step_out_t  core_out;
	logic       step;
	logic       take;

	tts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.timing  (timing)
	);

	assign step = item_valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !item_valid_s1 || step;
	assign take = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_valid_s1 <= 1'b0;
		else
			item_valid_s1 <= take | (item_valid_s1 & ~step);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.operation <= item.operation;
			item_s1.status[0] <= status_t'(item.first_status);
			item_s1.status[1] <= status_t'(item.second_status);
			item_s1.status[2] <= status_t'(item.third_status);
		end
	end

	tts_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.step_in  (item_s1),
		.timing   (timing),
		.step_out (core_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else
			res_valid_q <= step | (res_valid_q & ~result.ready);
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= core_out;
	end

	assign result.valid          = res_valid_q;
	assign result.first_command  = res_q.command[0];
	assign result.second_command = res_q.command[1];
	assign result.third_command  = res_q.command[2];
	assign result.run_mode       = res_q.run_mode;
	assign result.aborted        = res_q.aborted;

endmodule
